[src/sdr_pkg.sv]
// ----------------------------------------------------------------------------
// sdr_pkg: shared types and constants for the sample delta rate block
// Register map, sample type codes and the tag that travels down the pipeline.
// ----------------------------------------------------------------------------
package sdr_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS    = 64;
  localparam int INTERVAL_FIELD = 16;
  localparam int MAG_BITS       = 64;
  localparam int TYPE_BITS      = 4;
  localparam int FLAG_BITS      = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_ADDR_BITS  = 3;

  // register indexes (paddr[2])
  localparam logic REG_SAMPLE_TYPE = 1'b0;
  localparam logic REG_PROC_FLAGS  = 1'b1;

  // width select, low two bits of sample_type
  localparam logic [1:0] WSEL_8  = 2'd0;
  localparam logic [1:0] WSEL_16 = 2'd1;
  localparam logic [1:0] WSEL_32 = 2'd2;
  localparam logic [1:0] WSEL_64 = 2'd3;

  // highest supported sample type code, first unsigned code
  localparam logic [TYPE_BITS-1:0] TYPE_LAST_VALID = 4'd7;
  localparam logic [TYPE_BITS-1:0] TYPE_FIRST_UNS  = 4'd4;

  // processing flag bits
  localparam int FLAG_DIFF = 0;
  localparam int FLAG_RATE = 1;

  // control tag carried alongside the data in every stage
  typedef struct packed {
    logic vld;
    logic neg;
    logic err;
  } sdr_tag_t;

endpackage

[src/sdr_in_if.sv]
// ----------------------------------------------------------------------------
// sdr_in_if: sample request channel
// Valid/ready channel carrying a sample pair and the sampling interval.
// ----------------------------------------------------------------------------
interface sdr_in_if
  import sdr_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [SAMPLE_BITS-1:0]    current_sample;
  logic [SAMPLE_BITS-1:0]    previous_sample;
  logic [INTERVAL_FIELD-1:0] interval_seconds;

  modport source (
    output valid, current_sample, previous_sample, interval_seconds,
    input  ready
  );

  modport sink (
    input  valid, current_sample, previous_sample, interval_seconds,
    output ready
  );
endinterface

[src/sdr_out_if.sv]
// ----------------------------------------------------------------------------
// sdr_out_if: result request channel
// Valid/ready channel carrying the sign-magnitude result and its flags.
// ----------------------------------------------------------------------------
interface sdr_out_if
  import sdr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [MAG_BITS-1:0] magnitude;
  logic                negative;
  logic                type_error;

  modport source (
    output valid, magnitude, negative, type_error,
    input  ready
  );

  modport sink (
    input  valid, magnitude, negative, type_error,
    output ready
  );
endinterface

[src/sample_delta_rate.sv]
// ----------------------------------------------------------------------------
// sample_delta_rate: counter sample delta and rate
// Turns a sample pair into a sign-magnitude value, optionally divided by the
// sampling interval through a chain of restoring division cells.
// ----------------------------------------------------------------------------
// pipeline: DATA_WIDTH + 1 register stages
// throughput: one request per cycle while the chain is not stalled; one magnitude
//   stage, then one cell per quotient bit, each cell a registered stage
// the whole chain stalls together whenever a result waits in the last cell
//   and out_chan.ready is low
// reset: synchronous active-low rst_n clears all stage valids and the config registers only

module sample_delta_rate
  import sdr_pkg::*;
#(
  parameter int DATA_WIDTH    = 64,
  parameter int INTERVAL_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  sdr_in_if.sink                   in_chan,
  sdr_out_if.source                out_chan,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int DW       = DATA_WIDTH;
  localparam int DIV_BITS = (INTERVAL_BITS < INTERVAL_FIELD) ? INTERVAL_BITS : INTERVAL_FIELD;

  logic [TYPE_BITS-1:0] sample_type_r;
  logic [FLAG_BITS-1:0] proc_flags_r;
  logic                 en;

  sdr_tag_t            tag  [0:DW];
  logic [DIV_BITS-1:0] rem  [0:DW];
  logic [DW-1:0]       work [0:DW];
  logic [DIV_BITS-1:0] dvsr [0:DW];

  // configuration registers
  sdr_cfg_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .sample_type_r (sample_type_r),
    .proc_flags_r  (proc_flags_r)
  );

  // chain advances unless a held result blocks it
  assign en            = !tag[DW].vld || out_chan.ready;
  assign in_chan.ready = en;

  // magnitude stage
  sdr_front #(
    .DW       (DW),
    .DIV_BITS (DIV_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .req_vld     (in_chan.valid),
    .cur_sample  (in_chan.current_sample),
    .prev_sample (in_chan.previous_sample),
    .interval    (in_chan.interval_seconds),
    .sample_type (sample_type_r),
    .proc_flags  (proc_flags_r),
    .mag_r       (work[0]),
    .div_r       (dvsr[0]),
    .tag_r       (tag[0])
  );

  assign rem[0] = '0;

  // divider chain, one quotient bit per cell
  for (genvar g = 0; g < DW; g++) begin : g_cell
    sdr_div_cell #(
      .DW       (DW),
      .DIV_BITS (DIV_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .tag_in  (tag[g]),
      .rem_in  (rem[g]),
      .work_in (work[g]),
      .div_in  (dvsr[g]),
      .tag_r   (tag[g+1]),
      .rem_r   (rem[g+1]),
      .work_r  (work[g+1]),
      .div_r   (dvsr[g+1])
    );
  end

  // result from the last cell
  assign out_chan.valid      = tag[DW].vld;
  assign out_chan.magnitude  = MAG_BITS'(work[DW]);
  assign out_chan.negative   = tag[DW].neg;
  assign out_chan.type_error = tag[DW].err;

  // an accepted request enters the magnitude stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> tag[0].vld)
    else $error("accepted request did not enter the magnitude stage");

  // unsupported type gives an empty result
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.type_error) |->
      (out_chan.magnitude == '0) && !out_chan.negative)
    else $error("type error with nonzero magnitude or sign");

  // 8-bit types never produce bits above the type width
  a_width8: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (sample_type_r[1:0] == WSEL_8)) |->
      (out_chan.magnitude[MAG_BITS-1:8] == '0))
    else $error("8-bit result wider than its type");

  // without division a negative result has a nonzero magnitude
  a_neg_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.negative && !proc_flags_r[FLAG_RATE]) |->
      (out_chan.magnitude != '0))
    else $error("negative flag with zero magnitude");

endmodule

[src/sdr_cfg_regs.sv]
// ----------------------------------------------------------------------------
// sdr_cfg_regs: configuration registers
// APB-style write/read access to sample_type and processing_flags.
// ----------------------------------------------------------------------------
module sdr_cfg_regs
  import sdr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [TYPE_BITS-1:0]     sample_type_r,
  output logic [FLAG_BITS-1:0]     proc_flags_r
);

  logic                 wr_en;
  logic                 reg_idx;
  logic [TYPE_BITS-1:0] sample_type_nxt;
  logic [FLAG_BITS-1:0] proc_flags_nxt;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  // register write decode
  always_comb begin
    sample_type_nxt = sample_type_r;
    proc_flags_nxt  = proc_flags_r;
    if (wr_en) begin
      case (reg_idx)
        REG_SAMPLE_TYPE: sample_type_nxt = pwdata[TYPE_BITS-1:0];
        REG_PROC_FLAGS:  proc_flags_nxt  = pwdata[FLAG_BITS-1:0];
        default:         sample_type_nxt = sample_type_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_type_r <= '0;
      proc_flags_r  <= '0;
    end else begin
      sample_type_r <= sample_type_nxt;
      proc_flags_r  <= proc_flags_nxt;
    end
  end

  // read mux
  always_comb begin
    case (reg_idx)
      REG_SAMPLE_TYPE: prdata = CFG_DATA_BITS'(sample_type_r);
      REG_PROC_FLAGS:  prdata = CFG_DATA_BITS'(proc_flags_r);
      default:         prdata = '0;
    endcase
  end

endmodule

[src/sdr_front.sv]
// ----------------------------------------------------------------------------
// sdr_front: magnitude stage
// Masks the samples to the type width, forms value or delta, splits sign and
// magnitude and picks the divisor for the divider chain.
// ----------------------------------------------------------------------------
module sdr_front
  import sdr_pkg::*;
#(
  parameter int DW       = 64,
  parameter int DIV_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      req_vld,
  input  logic [SAMPLE_BITS-1:0]    cur_sample,
  input  logic [SAMPLE_BITS-1:0]    prev_sample,
  input  logic [INTERVAL_FIELD-1:0] interval,
  input  logic [TYPE_BITS-1:0]      sample_type,
  input  logic [FLAG_BITS-1:0]      proc_flags,
  output logic [DW-1:0]             mag_r,
  output logic [DIV_BITS-1:0]       div_r,
  output sdr_tag_t                  tag_r
);

  logic [6:0]          wbits;
  logic                width_ok;
  logic                type_ok;
  logic                is_signed;
  logic [DW-1:0]       msk;
  logic [DW-1:0]       sbit;
  logic [DW-1:0]       cur_m;
  logic [DW-1:0]       prev_m;
  logic [DW-1:0]       fwd;
  logic [DW-1:0]       bwd;
  logic [DW-1:0]       sval;
  logic                sneg;
  logic                borrow;
  logic [DW-1:0]       mag_nxt;
  logic                neg_nxt;
  logic [DIV_BITS-1:0] dfield;
  logic [DIV_BITS-1:0] div_nxt;
  sdr_tag_t            tag_nxt;

  // type width and support check
  always_comb begin
    case (sample_type[1:0])
      WSEL_8:  begin wbits = 7'd8;  width_ok = 1'b1;     end
      WSEL_16: begin wbits = 7'd16; width_ok = (DW >= 16); end
      WSEL_32: begin wbits = 7'd32; width_ok = (DW >= 32); end
      WSEL_64: begin wbits = 7'd64; width_ok = (DW >= 64); end
      default: begin wbits = 7'd8;  width_ok = 1'b1;     end
    endcase
    type_ok   = (sample_type <= TYPE_LAST_VALID) && width_ok;
    is_signed = (sample_type < TYPE_FIRST_UNS);
  end

  // width mask and sign bit position
  always_comb begin
    for (int i = 0; i < DW; i++) begin
      msk[i] = (7'(i) < wbits);
    end
    sbit = msk ^ (msk >> 1);
  end

  // masked samples and both directions of the delta
  assign cur_m  = cur_sample[DW-1:0] & msk;
  assign prev_m = prev_sample[DW-1:0] & msk;
  assign fwd    = (cur_m - prev_m) & msk;
  assign bwd    = (prev_m - cur_m) & msk;
  assign borrow = (prev_m > cur_m);

  // signed value and its sign
  assign sval = proc_flags[FLAG_DIFF] ? fwd : cur_m;
  assign sneg = |(sval & sbit);

  // sign-magnitude select
  always_comb begin
    mag_nxt = cur_m;
    neg_nxt = 1'b0;
    if (!type_ok) begin
      mag_nxt = '0;
    end else if (is_signed) begin
      neg_nxt = sneg;
      mag_nxt = sneg ? ((~sval + DW'(1)) & msk) : sval;
    end else if (proc_flags[FLAG_DIFF]) begin
      neg_nxt = borrow;
      mag_nxt = borrow ? bwd : fwd;
    end
  end

  // divisor: one when rate mode is off or the interval is zero
  assign dfield  = interval[DIV_BITS-1:0];
  assign div_nxt = (proc_flags[FLAG_RATE] && (dfield != '0)) ? dfield : DIV_BITS'(1);

  always_comb begin
    tag_nxt.vld = req_vld;
    tag_nxt.neg = neg_nxt;
    tag_nxt.err = !type_ok;
  end

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      div_r <= div_nxt;
    end
  end

endmodule

[src/sdr_div_cell.sv]
// ----------------------------------------------------------------------------
// sdr_div_cell: one restoring division step
// Shifts one dividend bit into the partial remainder, subtracts the divisor
// when it fits and shifts the quotient bit into the work word.
// ----------------------------------------------------------------------------
module sdr_div_cell
  import sdr_pkg::*;
#(
  parameter int DW       = 64,
  parameter int DIV_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  sdr_tag_t            tag_in,
  input  logic [DIV_BITS-1:0] rem_in,
  input  logic [DW-1:0]       work_in,
  input  logic [DIV_BITS-1:0] div_in,
  output sdr_tag_t            tag_r,
  output logic [DIV_BITS-1:0] rem_r,
  output logic [DW-1:0]       work_r,
  output logic [DIV_BITS-1:0] div_r
);

  logic [DIV_BITS:0]   trial;
  logic [DIV_BITS:0]   diff;
  logic                fits;
  logic [DIV_BITS-1:0] rem_nxt;
  logic [DW-1:0]       work_nxt;

  // trial subtract
  assign trial    = {rem_in, work_in[DW-1]};
  assign diff     = trial - {1'b0, div_in};
  assign fits     = (trial >= {1'b0, div_in});
  assign rem_nxt  = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
  assign work_nxt = {work_in[DW-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      work_r <= work_nxt;
      div_r  <= div_in;
    end
  end

endmodule
